>>> hdl/mexc_pkg.sv
// Package for the modular exponentiation check block: sizes, register codes,
// reset values and the sequencer state type.
// No dependencies.
package mexc_pkg;

  localparam int WORD_BITS_DEF = 32;   // datapath width of the arithmetic
  localparam int FIELD_BITS    = 32;   // width of every word field on the ports
  localparam int CFG_IDX_BITS  = 2;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_EXPONENT = 2'd0;
  localparam cfg_idx_t REG_MODULUS  = 2'd1;

  localparam logic [FIELD_BITS-1:0] EXPONENT_RESET = 32'h0001_0001;
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET  = 32'hc0c9_eb8d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

endpackage

>>> hdl/mexc_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
// Operand a must already be below m. Uses no package items.
module mexc_mulmod #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] op_a,
  input  logic [WORD_BITS-1:0] op_b,
  input  logic [WORD_BITS-1:0] op_m,
  output logic                 done,
  output logic [WORD_BITS-1:0] res
);

  localparam int CNT_BITS = $clog2(WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  logic [WORD_BITS-1:0] a_r, b_r, m_r, r_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 busy_r, done_r;

  // one double-and-add step: s = 2r + bit*a < 3m, take s - k*m for the k that lands in [0, m)
  logic [WORD_BITS+1:0] sum;
  logic [WORD_BITS+2:0] diff1, diff2;
  logic [WORD_BITS-1:0] r_nxt;

  always_comb begin
    sum   = {1'b0, r_r, 1'b0} + (b_r[WORD_BITS-1] ? {2'b00, a_r} : '0);
    diff1 = {1'b0, sum} - {3'b000, m_r};
    diff2 = {1'b0, sum} - {2'b00, m_r, 1'b0};
    if (!diff2[WORD_BITS+2]) begin
      r_nxt = diff2[WORD_BITS-1:0];
    end else if (!diff1[WORD_BITS+2]) begin
      r_nxt = diff1[WORD_BITS-1:0];
    end else begin
      r_nxt = sum[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_LAST;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
      m_r <= op_m;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= {b_r[WORD_BITS-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign res  = r_r;

  a_partial_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (r_r < m_r))
    else $error("partial product not below modulus");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("start did not begin a multiplication");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done raised while still busy");

endmodule

>>> hdl/modular_exponentiation_check.sv
// Top level of the modular exponentiation check: register file, sequencer,
// output register. Depends on mexc_pkg and mexc_mulmod.
//
// Use:
//   Configuration words on cfg_* set the exponent (index 0) and the modulus
//   (index 1); a zero written to the modulus is dropped, other indexes are
//   ignored. cfg_ready is always high. Write only while the block is idle.
//   Each input word on in_* carries a base and an expected value; the block
//   returns one output word: base^exponent mod modulus, and a match flag.
//   An exponent of zero gives 1, even with a modulus of one.
// Operation:
//   One item at a time: in_tready is high only in the idle state. The base is
//   first reduced, then each exponent bit up to the top set one costs one
//   dispatch step, a multiply for a set bit and then a square, all in the one
//   shared bit-serial multiplier. The sequencer returns to the idle state
//   before the next word is taken.
// Reset: rst_n is synchronous, active low; registers take their reset values,
//   the sequencer goes idle and any pending output word is dropped.
// Stall: a result waits in the output register; a new input is taken
//   meanwhile, and the sequencer holds at the end until the register frees.
module modular_exponentiation_check #(
  parameter int WORD_BITS = mexc_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  mexc_pkg::cfg_idx_t            cfg_index,
  input  logic [mexc_pkg::FIELD_BITS-1:0] cfg_data,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*mexc_pkg::FIELD_BITS-1:0] in_tdata,  // [31:0] base, [63:32] expected
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mexc_pkg::FIELD_BITS-1:0] out_tdata,   // [31:0] result
  output logic                          out_tuser    // [0] matches_res
);

  localparam int FB = mexc_pkg::FIELD_BITS;
  localparam logic [WORD_BITS-1:0] ONE = {{(WORD_BITS-1){1'b0}}, 1'b1};

  // port-width words fitted to the datapath width (zero extend or keep the low bits)
  logic [WORD_BITS+FB-1:0] cfg_wide, base_wide, exp_wide, erst_wide, mrst_wide;
  logic [WORD_BITS-1:0]    cfg_word, in_base, in_expected, exp_reset, mod_reset;

  assign cfg_wide    = {{WORD_BITS{1'b0}}, cfg_data};
  assign base_wide   = {{WORD_BITS{1'b0}}, in_tdata[FB-1:0]};
  assign exp_wide    = {{WORD_BITS{1'b0}}, in_tdata[2*FB-1:FB]};
  assign erst_wide   = {{WORD_BITS{1'b0}}, mexc_pkg::EXPONENT_RESET};
  assign mrst_wide   = {{WORD_BITS{1'b0}}, mexc_pkg::MODULUS_RESET};
  assign cfg_word    = cfg_wide[WORD_BITS-1:0];
  assign in_base     = base_wide[WORD_BITS-1:0];
  assign in_expected = exp_wide[WORD_BITS-1:0];
  assign exp_reset   = erst_wide[WORD_BITS-1:0];
  assign mod_reset   = mrst_wide[WORD_BITS-1:0];

  // ---------------- configuration registers ----------------
  logic [WORD_BITS-1:0] exponent_r, modulus_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= exp_reset;
      modulus_r  <= mod_reset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mexc_pkg::REG_EXPONENT: exponent_r <= cfg_word;
        mexc_pkg::REG_MODULUS: begin
          if (cfg_word != '0) modulus_r <= cfg_word;   // zero modulus refused
        end
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  mexc_pkg::state_t state_r, state_nxt;

  logic                 mm_start, mm_done;
  logic [WORD_BITS-1:0] mm_a, mm_b, mm_m, mm_res;

  // working registers of one item
  logic [WORD_BITS-1:0] e_r, e_nxt;       // exponent bits still to use
  logic [WORD_BITS-1:0] m_r, m_nxt;       // modulus latched at accept
  logic [WORD_BITS-1:0] b_r, b_nxt;       // current base power, reduced
  logic [WORD_BITS-1:0] acc_r, acc_nxt;   // running result
  logic [WORD_BITS-1:0] expd_r, expd_nxt; // expected value

  logic out_free;
  assign out_free = !out_tvalid || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexc_pkg::ST_IDLE:   if (in_tvalid) state_nxt = mexc_pkg::ST_REDUCE;
      mexc_pkg::ST_REDUCE: if (mm_done) state_nxt = mexc_pkg::ST_STEP;
      mexc_pkg::ST_STEP: begin
        if (e_r == '0)    state_nxt = mexc_pkg::ST_DONE;
        else if (e_r[0])  state_nxt = mexc_pkg::ST_MUL;
        else              state_nxt = mexc_pkg::ST_SQR;
      end
      mexc_pkg::ST_MUL:    if (mm_done) state_nxt = mexc_pkg::ST_SQR;
      mexc_pkg::ST_SQR:    if (mm_done) state_nxt = mexc_pkg::ST_STEP;
      mexc_pkg::ST_DONE:   if (out_free) state_nxt = mexc_pkg::ST_IDLE;
      default:             state_nxt = mexc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and multiplier operands
  always_comb begin
    in_tready = 1'b0;
    mm_start  = 1'b0;
    mm_a      = b_r;
    mm_b      = b_r;
    mm_m      = m_r;
    unique case (state_r)
      mexc_pkg::ST_IDLE: begin
        // reduce the base: 1 (or 0 for a modulus of one) times base
        in_tready = 1'b1;
        mm_start  = in_tvalid;
        mm_a      = (modulus_r == ONE) ? '0 : ONE;
        mm_b      = in_base;
        mm_m      = modulus_r;
      end
      mexc_pkg::ST_STEP: begin
        mm_start = (e_r != '0);
        mm_a     = e_r[0] ? acc_r : b_r;
      end
      mexc_pkg::ST_MUL:    mm_start = mm_done;   // square follows straight on
      mexc_pkg::ST_REDUCE,
      mexc_pkg::ST_SQR,
      mexc_pkg::ST_DONE:   ;
      default:             ;
    endcase
  end

  // working register updates
  always_comb begin
    e_nxt    = e_r;
    m_nxt    = m_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    expd_nxt = expd_r;
    case (state_r)
      mexc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          e_nxt    = exponent_r;
          m_nxt    = modulus_r;
          expd_nxt = in_expected;
          // zero exponent keeps 1 unreduced; otherwise 1 mod m
          acc_nxt  = (exponent_r != '0 && modulus_r == ONE) ? '0 : ONE;
        end
      end
      mexc_pkg::ST_REDUCE: if (mm_done) b_nxt = mm_res;
      mexc_pkg::ST_MUL:    if (mm_done) acc_nxt = mm_res;
      mexc_pkg::ST_SQR: begin
        if (mm_done) begin
          b_nxt = mm_res;
          e_nxt = e_r >> 1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    m_r    <= m_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    expd_r <= expd_nxt;
  end

  mexc_mulmod #(
    .WORD_BITS (WORD_BITS)
  ) u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .op_a  (mm_a),
    .op_b  (mm_b),
    .op_m  (mm_m),
    .done  (mm_done),
    .res   (mm_res)
  );

  // ---------------- output register ----------------
  logic                 out_valid_r, out_valid_nxt;
  logic [FB-1:0]        out_data_r, out_data_nxt;
  logic                 out_match_r, out_match_nxt;
  logic [WORD_BITS+FB-1:0] acc_wide;
  logic                 load_out;

  assign acc_wide = {{FB{1'b0}}, acc_r};
  assign load_out = (state_r == mexc_pkg::ST_DONE) && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_match_nxt = out_match_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = acc_wide[FB-1:0];
      out_match_nxt = (acc_r == expd_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_match_r <= out_match_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_match_r;

  // ---------------- checks ----------------
  a_done_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    mm_done |-> (state_r == mexc_pkg::ST_REDUCE || state_r == mexc_pkg::ST_MUL ||
                 state_r == mexc_pkg::ST_SQR))
    else $error("multiplier result arrived with no consumer");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == mexc_pkg::ST_REDUCE)
    else $error("accepted word did not start base reduction");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mexc_pkg::ST_SQR |-> acc_r < m_r)
    else $error("running result not below modulus");

  a_base_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mexc_pkg::ST_STEP |-> b_r < m_r)
    else $error("base power not below modulus");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_tvalid && state_r == mexc_pkg::ST_IDLE)
    else $error("finished result not presented");

endmodule
